[rtl/stripe_range_splitter_assert.svh]
// Assertion macros included by stripe_range_splitter.sv, the RTL file that carries checks.
`ifndef STRIPE_RANGE_SPLITTER_ASSERT_SVH
`define STRIPE_RANGE_SPLITTER_ASSERT_SVH
`ifndef SYNTHESIS
`define SRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/srs_pkg.sv]
`default_nettype none
package srs_pkg;

    localparam int MAX_CHUNKS = 16;
    localparam logic [20:0] SIZE_LIMIT = 21'd1048576;
    localparam logic [20:0] SIZE_RESET = 21'd4096;
    localparam logic [4:0] COUNT_RESET = 5'd4;

    typedef enum logic [0:0] {
        CFG_CHUNK_SIZE  = 1'b0,
        CFG_CHUNK_COUNT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DEAD   = 2'd1,
        ST_BEYOND = 2'd2,
        ST_ZERO   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_WALK = 2'd1,
        S_EMIT = 2'd2,
        S_ERR  = 2'd3
    } state_t;

    typedef struct packed {
        logic [24:0] next;
        logic        start_below;
        logic        end_below;
    } step_t;

endpackage
`default_nettype wire

[rtl/srs_cfg_regs.sv]
`default_nettype none
module srs_cfg_regs
    import srs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [20:0] cfg_wdata,
    output logic      [20:0] size_eff,
    output logic      [4:0]  count_eff
);

    logic [20:0] size_reg;
    logic [4:0]  count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_RESET;
            count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_CHUNK_SIZE:  size_reg  <= cfg_wdata;
                CFG_CHUNK_COUNT: count_reg <= cfg_wdata[4:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (size_reg == 21'd0)
            size_eff = 21'd1;
        else if (size_reg > SIZE_LIMIT)
            size_eff = SIZE_LIMIT;
        else
            size_eff = size_reg;

        if (count_reg == 5'd0)
            count_eff = 5'd1;
        else if (count_reg > 5'(MAX_CHUNKS))
            count_eff = 5'(MAX_CHUNKS);
        else
            count_eff = count_reg;
    end

endmodule
`default_nettype wire

[rtl/srs_step_unit.sv]
`default_nettype none
module srs_step_unit
    import srs_pkg::*;
(
    input  wire logic [24:0] base,
    input  wire logic [20:0] size,
    input  wire logic [31:0] start,
    input  wire logic [32:0] stop,
    output step_t            step
);

    // One adder moves to the next chunk boundary; both range ends are compared to it.
    always_comb
    begin
        step.next        = base + {4'd0, size};
        step.start_below = start < {7'd0, step.next};
        step.end_below   = stop < {8'd0, step.next};
    end

endmodule
`default_nettype wire

[rtl/stripe_range_splitter.sv]
`default_nettype none
`include "stripe_range_splitter_assert.svh"
// Splits a byte range into one word per stripe chunk it touches. After a word is accepted,
// the boundary walker visits the chunks in turn from chunk 0 up to the end chunk (at most
// the chunk count, so 16 chunks), stepping a single shared adder and two comparators along the
// chunk boundaries; then one word per touched chunk leaves, one per cycle when the output
// is free. A request with zero length skips the walk. Errors give a single word.
module stripe_range_splitter
    import srs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [20:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // start_offset, range_length, alive_mask
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // chunk_index, offset_in_chunk, piece_length, zero pad
    output logic      [1:0]  m_tuser,   // status
    output logic             m_tlast
);

    logic [20:0] size_eff;
    logic [4:0]  count_eff;
    step_t       step;

    state_t      state_reg, state_next;
    logic [31:0] start_reg, start_next;
    logic [32:0] end_reg, end_next;
    logic [20:0] len_reg, len_next;
    logic [15:0] alive_reg, alive_next;
    logic [3:0]  idx_reg, idx_next;
    logic [24:0] base_reg, base_next;
    logic        sc_found_reg, sc_found_next;
    logic [3:0]  sc_reg, sc_next;
    logic [24:0] base_sc_reg, base_sc_next;
    logic [3:0]  ec_reg, ec_next;
    logic [24:0] base_ec_reg, base_ec_next;
    logic        dead_found_reg, dead_found_next;
    logic [3:0]  dead_idx_reg, dead_idx_next;
    status_t     err_status_reg, err_status_next;
    logic [3:0]  err_idx_reg, err_idx_next;

    logic        out_valid_reg, out_valid_next;
    logic [3:0]  out_idx_reg, out_idx_next;
    logic [19:0] out_off_reg, out_off_next;
    logic [20:0] out_len_reg, out_len_next;
    status_t     out_status_reg, out_status_next;
    logic        out_last_reg, out_last_next;

    logic        out_free;
    logic        in_range;
    logic        dead_now;
    logic        is_first;
    logic        is_last;
    logic [24:0] off_wide;
    logic [24:0] tail_wide;
    logic [19:0] off_val;

    srs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .size_eff  (size_eff),
        .count_eff (count_eff)
    );

    srs_step_unit u_step (
        .base  (base_reg),
        .size  (size_eff),
        .start (start_reg),
        .stop  (end_reg),
        .step  (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        end_reg        <= end_next;
        len_reg        <= len_next;
        alive_reg      <= alive_next;
        idx_reg        <= idx_next;
        base_reg       <= base_next;
        sc_found_reg   <= sc_found_next;
        sc_reg         <= sc_next;
        base_sc_reg    <= base_sc_next;
        ec_reg         <= ec_next;
        base_ec_reg    <= base_ec_next;
        dead_found_reg <= dead_found_next;
        dead_idx_reg   <= dead_idx_next;
        err_status_reg <= err_status_next;
        err_idx_reg    <= err_idx_next;
        out_idx_reg    <= out_idx_next;
        out_off_reg    <= out_off_next;
        out_len_reg    <= out_len_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        len_next        = len_reg;
        alive_next      = alive_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        sc_found_next   = sc_found_reg;
        sc_next         = sc_reg;
        base_sc_next    = base_sc_reg;
        ec_next         = ec_reg;
        base_ec_next    = base_ec_reg;
        dead_found_next = dead_found_reg;
        dead_idx_next   = dead_idx_reg;
        err_status_next = err_status_reg;
        err_idx_next    = err_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_idx_next    = out_idx_reg;
        out_off_next    = out_off_reg;
        out_len_next    = out_len_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        out_free  = !out_valid_reg || m_tready;
        s_tready  = (state_reg == S_IDLE);
        in_range  = sc_found_reg || step.start_below;
        dead_now  = in_range && !alive_reg[idx_reg];
        is_first  = (idx_reg == sc_reg);
        is_last   = (idx_reg == ec_reg);
        off_wide  = start_reg[24:0] - base_sc_reg;
        off_val   = is_first ? off_wide[19:0] : 20'd0;
        tail_wide = end_reg[24:0] - base_ec_reg + 25'd1;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    start_next      = s_tdata[31:0];
                    end_next        = {1'b0, s_tdata[31:0]} + {1'b0, s_tdata[63:32]} - 33'd1;
                    len_next        = s_tdata[52:32];
                    alive_next      = s_tdata[79:64];
                    idx_next        = 4'd0;
                    base_next       = 25'd0;
                    sc_found_next   = 1'b0;
                    dead_found_next = 1'b0;
                    if (s_tdata[63:32] == 32'd0)
                    begin
                        err_status_next = ST_ZERO;
                        err_idx_next    = 4'd0;
                        state_next      = S_ERR;
                    end
                    else
                        state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (in_range && !sc_found_reg)
                begin
                    sc_found_next = 1'b1;
                    sc_next       = idx_reg;
                    base_sc_next  = base_reg;
                end
                if (dead_now && !dead_found_reg)
                begin
                    dead_found_next = 1'b1;
                    dead_idx_next   = idx_reg;
                end
                if (step.end_below)
                begin
                    ec_next      = idx_reg;
                    base_ec_next = base_reg;
                    if (dead_found_reg || dead_now)
                    begin
                        err_status_next = ST_DEAD;
                        err_idx_next    = dead_found_reg ? dead_idx_reg : idx_reg;
                        state_next      = S_ERR;
                    end
                    else
                    begin
                        idx_next   = sc_found_reg ? sc_reg : idx_reg;
                        state_next = S_EMIT;
                    end
                end
                else if ({1'b0, idx_reg} == count_eff - 5'd1)
                begin
                    err_status_next = ST_BEYOND;
                    err_idx_next    = 4'd0;
                    state_next      = S_ERR;
                end
                else
                begin
                    idx_next  = idx_reg + 4'd1;
                    base_next = step.next;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = idx_reg;
                    out_off_next    = off_val;
                    out_status_next = ST_OK;
                    out_last_next   = is_last;
                    if (is_first && is_last)
                        out_len_next = len_reg;
                    else if (is_first)
                        out_len_next = size_eff - {1'b0, off_val};
                    else if (is_last)
                        out_len_next = tail_wide[20:0];
                    else
                        out_len_next = size_eff;
                    idx_next = idx_reg + 4'd1;
                    if (is_last)
                        state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = err_idx_reg;
                    out_off_next    = 20'd0;
                    out_len_next    = 21'd0;
                    out_status_next = err_status_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_len_reg, out_off_reg, out_idx_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    `SRS_ASSERT_IMPLY(a_err_single, clk, rst_n, m_tvalid && (m_tuser != ST_OK), m_tlast && (out_len_reg == 21'd0))
    `SRS_ASSERT_IMPLY(a_piece_fits, clk, rst_n, m_tvalid && (m_tuser == ST_OK), (out_len_reg != 21'd0) && (out_len_reg <= size_eff))
    `SRS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule
`default_nettype wire

[tb/srs_checker.sv]
`timescale 1ns / 1ps
module srs_checker
    import srs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [20:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [79:0] s_tdata,   // start_offset, range_length, alive_mask
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,   // chunk_index, offset_in_chunk, piece_length, zero pad
    input  wire logic [1:0]  m_tuser,   // status
    input  wire logic        m_tlast,
    output int               mismatches,
    output int               pending,
    output int               words_out,
    output int               error_words
);

    typedef struct {
        logic [3:0]  index;
        logic [19:0] offset;
        logic [20:0] length;
        status_t     status;
        logic        last;
    } piece_t;

    piece_t      pieces_due[$];
    logic [20:0] chunk_size;
    logic [4:0]  chunk_count;

    function automatic piece_t make_piece(logic [63:0] idx, logic [63:0] off,
                                          logic [63:0] len, status_t st, logic last);
        piece_t p;
        p.index  = idx[3:0];
        p.offset = off[19:0];
        p.length = len[20:0];
        p.status = st;
        p.last   = last;
        return p;
    endfunction

    function automatic void queue_piece(piece_t p);
        pieces_due.insert(pieces_due.size(), p);
    endfunction

    function automatic void split_range(logic [31:0] start, logic [31:0] len,
                                        logic [15:0] alive);
        logic [63:0] size_eff;
        logic [63:0] count_eff;
        logic [63:0] first_chunk;
        logic [63:0] last_chunk;
        logic [63:0] pos;
        logic [63:0] left;
        logic [63:0] tail;
        logic [63:0] piece;
        size_eff = (chunk_size == 0) ? 64'd1 :
                   (chunk_size > SIZE_LIMIT) ? 64'(SIZE_LIMIT) : 64'(chunk_size);
        count_eff = (chunk_count == 0) ? 64'd1 :
                    (chunk_count > MAX_CHUNKS) ? 64'(MAX_CHUNKS) : 64'(chunk_count);
        if (len == 0) begin
            queue_piece(make_piece(0, 0, 0, ST_ZERO, 1'b1));
            return;
        end
        first_chunk = 64'(start) / size_eff;
        last_chunk  = (64'(start) + 64'(len) - 64'd1) / size_eff;
        if (last_chunk >= count_eff) begin
            queue_piece(make_piece(0, 0, 0, ST_BEYOND, 1'b1));
            return;
        end
        for (logic [63:0] c = first_chunk; c <= last_chunk; c++) begin
            if (c >= 16 || !alive[c[3:0]]) begin
                queue_piece(make_piece(c, 0, 0, ST_DEAD, 1'b1));
                return;
            end
        end
        pos  = 64'(start);
        left = 64'(len);
        for (logic [63:0] c = first_chunk; c <= last_chunk; c++) begin
            tail  = size_eff * (c + 1) - pos;
            piece = (left < tail) ? left : tail;
            queue_piece(make_piece(c, pos - size_eff * c, piece, ST_OK,
                                   c == last_chunk));
            pos  = pos + piece;
            left = left - piece;
        end
    endfunction

    function automatic void report(string field, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, field, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        piece_t want;
        if (!rst_n)
        begin
            chunk_size  = SIZE_RESET;
            chunk_count = COUNT_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_CHUNK_SIZE:  chunk_size  = cfg_wdata;
                    CFG_CHUNK_COUNT: chunk_count = cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                split_range(s_tdata[31:0], s_tdata[63:32], s_tdata[79:64]);
            if (m_tvalid && m_tready)
            begin
                words_out++;
                if (m_tuser != ST_OK)
                    error_words++;
                if (pieces_due.size() == 0)
                begin
                    report("word with nothing expected", 32'h0, m_tdata[31:0]);
                end
                else
                begin
                    want = pieces_due.pop_front();
                    if (m_tdata[3:0] != want.index)
                        report("chunk_index", want.index, m_tdata[3:0]);
                    if (m_tdata[23:4] != want.offset)
                        report("offset_in_chunk", want.offset, m_tdata[23:4]);
                    if (m_tdata[44:24] != want.length)
                        report("piece_length", want.length, m_tdata[44:24]);
                    if (m_tdata[47:45] != 3'b000)
                        report("tdata pad", 32'h0, m_tdata[47:45]);
                    if (m_tuser != want.status)
                        report("status", want.status, m_tuser);
                    if (m_tlast != want.last)
                        report("last_piece", want.last, m_tlast);
                end
            end
            pending = pieces_due.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import srs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 30;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_addr;
    logic [20:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // start_offset, range_length, alive_mask
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // chunk_index, offset_in_chunk, piece_length, zero pad
    logic [1:0]  m_tuser;   // status
    logic        m_tlast;

    int mismatches;
    int pending;
    int words_out;
    int error_words;
    int cycles = 0;
    int words_in = 0;
    int geometries = 1;
    bit steady = 0;
    bit hold_go = 0;

    longint unsigned eff_size = 4096;
    int unsigned     eff_count = 4;

    logic [20:0] size_plan [8] = '{21'd1, 21'd0, 21'd1048576, 21'd2097151,
                                   21'd100, 21'd0, 21'd37, 21'd4096};
    logic [4:0]  count_plan [8] = '{5'd16, 5'd0, 5'd16, 5'd31, 5'd7, 5'd0, 5'd1, 5'd4};

    stripe_range_splitter DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    srs_checker range_check (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .mismatches(mismatches), .pending(pending),
        .words_out(words_out), .error_words(error_words)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !held)
            begin
                hold_left = HOLD_CYCLES;
                held = 1;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= steady || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [20:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(logic [20:0] size, logic [4:0] count);
        write_reg(CFG_CHUNK_SIZE, size);
        write_reg(CFG_CHUNK_COUNT, count);
        eff_size  = (size == 0) ? 1 : ((size > SIZE_LIMIT) ? SIZE_LIMIT : size);
        eff_count = (count == 0) ? 1 : ((count > MAX_CHUNKS) ? MAX_CHUNKS : count);
        geometries++;
    endtask

    task automatic send_word(logic [31:0] start, logic [31:0] len, logic [15:0] alive);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 25) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {alive, len, start};
        do @(posedge clk); while (!s_tready);
        words_in++;
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_word();
        longint unsigned span;
        longint unsigned start;
        longint unsigned len;
        longint unsigned room;
        logic [15:0]     alive;
        int unsigned     pick;
        span  = eff_size * eff_count;
        pick  = $urandom_range(0, 99);
        alive = 16'($urandom()) | 16'((32'd1 << eff_count) - 1);
        if (pick < 70)
        begin
            start = $urandom() % span;
            room  = span - start;
            if ($urandom_range(0, 1))
                len = 1 + $urandom() % room;
            else
                len = 1 + $urandom() % ((room < 3 * eff_size) ? room : 3 * eff_size);
            if ($urandom_range(0, 99) < 20)
                alive[$urandom_range(0, eff_count - 1)] = 1'b0;
        end
        else if (pick < 80)
        begin
            start = span - 1 - $urandom() % eff_size;
            len   = span - start + 1 + $urandom() % (2 * eff_size);
        end
        else if (pick < 88)
        begin
            start = $urandom();
            len   = 0;
            alive = 16'($urandom());
        end
        else
        begin
            start = $urandom();
            len   = $urandom();
            alive = 16'($urandom());
        end
        send_word(start[31:0], len[31:0], alive);
    endtask

    initial
    begin
        logic [20:0] size;
        logic [4:0]  count;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_CHUNK_SIZE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset geometry: 4 chunks of 4096 bytes.
        send_word(32'h0, 32'h0, 16'h0000);
        send_word(32'hFFFFFFFF, 32'h0, 16'hFFFF);
        send_word(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
        send_word(32'hFFFFFFFF, 32'h1, 16'hFFFF);
        send_word(32'd20000, 32'd1, 16'h0000);
        send_word(32'd0, 32'd1, 16'h0001);
        send_word(32'd0, 32'd16384, 16'hFFFF);
        send_word(32'd4095, 32'd2, 16'h0003);
        send_word(32'd16383, 32'd1, 16'h0008);
        send_word(32'd16383, 32'd2, 16'hFFFF);
        send_word(32'd0, 32'd16384, 16'hFFF7);
        send_word(32'd100, 32'd10, 16'hFFFE);
        send_word(32'd0, 32'd16384, 16'hFFF5);
        send_word(32'd8192, 32'd4096, 16'h0004);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            size  = size_plan[p];
            count = count_plan[p];
            if (p == 5)
            begin
                size  = 21'($urandom_range(2, 5000));
                count = 5'($urandom_range(2, 16));
            end
            set_geometry(size, count);
            steady = (p == 2);
            if (p == 0)
            begin
                send_word(32'd0, 32'd16, 16'hFFFF);
                send_word(32'd15, 32'd1, 16'h7FFF);
                send_word(32'd0, 32'd17, 16'hFFFF);
                hold_go = 1;
            end
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (i == PHASE_WORDS / 2)
                    settle();
                random_word();
            end
            settle();
        end
        steady = 0;

        $display("Ran %0d request words over %0d chunk geometries, saturated ones included.",
                 words_in, geometries);
        $display("Checked %0d result words, %0d of them error words.", words_out, error_words);
        if (mismatches == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/srs_pkg.sv
rtl/srs_cfg_regs.sv
rtl/srs_step_unit.sv
rtl/stripe_range_splitter.sv
tb/srs_checker.sv
tb/tb_top.sv
